[rtl/ocpp_pkg.sv]
// shared types, constants and the arctangent table of the omni camera projection
// no dependencies; every other file imports this package
package ocpp_pkg;

  localparam int MAX_COEFS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int CORDIC_STEPS    = 31;
  localparam int COEF_W          = 48;
  localparam int PIX_W           = 32;
  localparam int MUL_A_W         = 48;
  localparam int MUL_B_W         = 32;
  localparam int PROD_W          = MUL_A_W + MUL_B_W;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CENTER_COL = 3'd0;
  localparam logic [2:0] REG_CENTER_ROW = 3'd1;
  localparam logic [2:0] REG_AFFINE_C   = 3'd2;
  localparam logic [2:0] REG_AFFINE_D   = 3'd3;
  localparam logic [2:0] REG_AFFINE_E   = 3'd4;
  localparam logic [2:0] REG_COEF_COUNT = 3'd5;

  // item modes
  localparam logic MODE_COEF_WRITE = 1'b0;
  localparam logic MODE_PROJECT    = 1'b1;

  // request into and response from the shared multiplier
  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  // atan(2^-i) in Q2.30, rounded
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd843314857;
      5'd1: v = 32'd497837829;
      5'd2: v = 32'd263043837;
      5'd3: v = 32'd133525159;
      5'd4: v = 32'd67021687;
      5'd5: v = 32'd33543516;
      5'd6: v = 32'd16775851;
      5'd7: v = 32'd8388437;
      5'd8: v = 32'd4194283;
      5'd9: v = 32'd2097149;
      default: v = 32'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

[rtl/ocpp_if.sv]
// valid/ready channel interfaces for projection items and pixel results
// depends on ocpp_pkg
interface ocpp_in_if import ocpp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [3:0]                    coef_index;
  logic signed [COEF_W-1:0]      coef_value;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source(output valid, mode, coef_index, coef_value, point_x, point_y, point_z,
                 input ready);
  modport sink(input valid, mode, coef_index, coef_value, point_x, point_y, point_z,
               output ready);
endinterface

interface ocpp_out_if import ocpp_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_col;
  logic signed [PIX_W-1:0] pixel_row;
  logic                    on_axis;
  logic                    saturated;

  modport source(output valid, pixel_col, pixel_row, on_axis, saturated, input ready);
  modport sink(input valid, pixel_col, pixel_row, on_axis, saturated, output ready);
endinterface

[rtl/ocpp_mul.sv]
// shared unsigned 48x32 multiplier, two passes through one 24x32 array
// depends on ocpp_pkg
module ocpp_mul import ocpp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int HALF_W = MUL_A_W / 2;

  logic                      busy_r;
  logic                      done_r;
  logic [HALF_W-1:0]         a_hi_r;
  logic [MUL_B_W-1:0]        b_r;
  logic [PROD_W-1:0]         acc_r;
  logic [HALF_W-1:0]         op_a;
  logic [MUL_B_W-1:0]        op_b;
  logic [HALF_W+MUL_B_W-1:0] part;

  // low half on start, high half on the following cycle
  assign op_a = busy_r ? a_hi_r : req.a[HALF_W-1:0];
  assign op_b = busy_r ? b_r : req.b;
  assign part = op_a * op_b;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= req.start && !busy_r;
      done_r <= busy_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (busy_r) begin
      acc_r <= acc_r + (PROD_W'(part) << HALF_W);
    end else if (req.start) begin
      acc_r  <= PROD_W'(part);
      a_hi_r <= req.a[MUL_A_W-1:HALF_W];
      b_r    <= req.b;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

[rtl/omni_camera_point_projection.sv]
// omni camera projection: world direction to pixel through the inverse polynomial
// depends on ocpp_pkg, ocpp_in_if, ocpp_out_if and ocpp_mul
//
//  port      dir  kind          carries
//  in_chan   in   valid/ready   mode, coef_index, coef_value, point_x/y/z
//  out_chan  out  valid/ready   pixel_col, pixel_row, on_axis, saturated
//  psel..    in   apb           center, affine and coef_count registers
//
// a projection runs from acceptance to the next ready through the pre-shift steps,
// 32 square root steps, 31 cordic steps, two divisions of 31 steps each and the
// products on the one shared multiplier
// a coefficient write or an on-axis point skips the square root, cordic and division steps
// synchronous active-low reset; in_chan is ready only while idle
// a finished result waits in the output register while the next item starts
module omni_camera_point_projection import ocpp_pkg::*; #(
  parameter int MAX_COEFS   = MAX_COEFS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ocpp_in_if.sink      in_chan,
  ocpp_out_if.source   out_chan,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int MW     = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam int CORD_W = MW + 4;
  localparam int CIW    = $clog2(MAX_COEFS);
  localparam int CNTW   = $clog2(MAX_COEFS + 1);
  localparam int ACC_W  = 45;
  localparam int HSUM_W = 53;
  localparam logic [MW-1:0] MAG_LIM = MW'(64'h8000_0000);
  localparam logic signed [HSUM_W-1:0] HSUM_MAX = 53'sh7FFF_FFFF_FFFF;
  localparam logic signed [HSUM_W-1:0] HSUM_MIN = -53'sh8000_0000_0000;
  localparam logic signed [ACC_W-1:0]  PIX_MAX  = 45'sh7FFF_FFFF;
  localparam logic signed [ACC_W-1:0]  PIX_MIN  = -45'sh8000_0000;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SHIFT = 4'd1;
  localparam logic [3:0] S_SQRT  = 4'd2;
  localparam logic [3:0] S_CORD  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_HLOAD = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_MWAIT = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // products
  localparam logic [2:0] OP_SQX  = 3'd0;
  localparam logic [2:0] OP_SQY  = 3'd1;
  localparam logic [2:0] OP_HORN = 3'd2;
  localparam logic [2:0] OP_PX   = 3'd3;
  localparam logic [2:0] OP_PY   = 3'd4;
  localparam logic [2:0] OP_XC   = 3'd5;
  localparam logic [2:0] OP_YD   = 3'd6;
  localparam logic [2:0] OP_XE   = 3'd7;

  // configuration registers
  logic signed [31:0] center_col_r, center_row_r, affine_c_r, affine_d_r, affine_e_r;
  logic [4:0]         coef_count_r;

  // control
  logic [3:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       div_y_r, div_y_nxt;
  logic       out_valid_r, out_valid_nxt;

  // datapath
  logic [MW-1:0]             ax_r, ax_nxt, ay_r, ay_nxt, az_r, az_nxt;
  logic                      x_neg_r, x_neg_nxt, y_neg_r, y_neg_nxt, z_neg_r, z_neg_nxt;
  logic [63:0]               sq_r, sq_nxt;
  logic [33:0]               srem_r, srem_nxt;
  logic [31:0]               root_r, root_nxt, norm_r, norm_nxt;
  logic signed [CORD_W-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [31:0]        theta_r, theta_nxt;
  logic [31:0]               drem_r, drem_nxt;
  logic [30:0]               dlow_r, dlow_nxt, dq_r, dq_nxt, rx_r, rx_nxt, ry_r, ry_nxt;
  logic signed [COEF_W-1:0]  rho_r, rho_nxt;
  logic [CNTW-1:0]           idx_r, idx_nxt, ncoef_r, ncoef_nxt;
  logic [CIW-1:0]            rd_idx_r, rd_idx_nxt;
  logic signed [COEF_W-1:0]  coef_q_r;
  logic [47:0]               px_r, px_nxt, py_r, py_nxt;
  logic                      px_neg_r, px_neg_nxt, py_neg_r, py_neg_nxt, mneg_r, mneg_nxt;
  logic signed [ACC_W-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic                      satf_r, satf_nxt, onaxis_r, onaxis_nxt;
  logic signed [PIX_W-1:0]   out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  logic                      out_on_r, out_on_nxt, out_sat_r, out_sat_nxt;

  logic signed [COEF_W-1:0]  coef_mem [MAX_COEFS];

  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic                      in_fire, cfg_wr, coef_wr;
  logic [COORD_WIDTH-1:0]    x_mag, y_mag, z_mag;
  logic [4:0]                cc;

  ocpp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign in_fire        = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_wr         = psel && penable && pwrite;
  assign pready         = 1'b1;
  assign coef_wr        = in_fire && (in_chan.mode == MODE_COEF_WRITE)
                          && (32'(in_chan.coef_index) < MAX_COEFS);

  assign x_mag = in_chan.point_x[COORD_WIDTH-1] ? (~in_chan.point_x + 1'b1) : in_chan.point_x;
  assign y_mag = in_chan.point_y[COORD_WIDTH-1] ? (~in_chan.point_y + 1'b1) : in_chan.point_y;
  assign z_mag = in_chan.point_z[COORD_WIDTH-1] ? (~in_chan.point_z + 1'b1) : in_chan.point_z;
  assign cc    = coef_count_r;

  // register read mux
  always_comb begin
    case (paddr[4:2])
      REG_CENTER_COL: prdata = center_col_r;
      REG_CENTER_ROW: prdata = center_row_r;
      REG_AFFINE_C:   prdata = affine_c_r;
      REG_AFFINE_D:   prdata = affine_d_r;
      REG_AFFINE_E:   prdata = affine_e_r;
      REG_COEF_COUNT: prdata = 32'(coef_count_r);
      default:        prdata = 32'd0;
    endcase
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r <= '0;
      center_row_r <= '0;
      affine_c_r   <= 32'sh4000_0000;
      affine_d_r   <= '0;
      affine_e_r   <= '0;
      coef_count_r <= 5'd1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_CENTER_COL: center_col_r <= pwdata;
        REG_CENTER_ROW: center_row_r <= pwdata;
        REG_AFFINE_C:   affine_c_r   <= pwdata;
        REG_AFFINE_D:   affine_d_r   <= pwdata;
        REG_AFFINE_E:   affine_e_r   <= pwdata;
        REG_COEF_COUNT: coef_count_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // coefficient table
  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[CIW'(in_chan.coef_index)] <= in_chan.coef_value;
    end
    coef_q_r <= coef_mem[rd_idx_r];
  end

  // multiplier operands by product
  always_comb begin
    logic [47:0] rho_mag;
    logic [31:0] th_mag, c_mag, d_mag, e_mag;
    rho_mag = rho_r[COEF_W-1] ? 48'(-rho_r) : 48'(rho_r);
    th_mag  = theta_r[31] ? 32'(-theta_r) : 32'(theta_r);
    c_mag   = affine_c_r[31] ? 32'(-affine_c_r) : 32'(affine_c_r);
    d_mag   = affine_d_r[31] ? 32'(-affine_d_r) : 32'(affine_d_r);
    e_mag   = affine_e_r[31] ? 32'(-affine_e_r) : 32'(affine_e_r);
    mreq.start = (state_r == S_MUL);
    mreq.a     = 48'(ax_r[31:0]);
    mreq.b     = ax_r[31:0];
    mneg_nxt   = mneg_r;
    case (op_r)
      OP_SQX: begin
        mreq.a = 48'(ax_r[31:0]);
        mreq.b = ax_r[31:0];
      end
      OP_SQY: begin
        mreq.a = 48'(ay_r[31:0]);
        mreq.b = ay_r[31:0];
      end
      OP_HORN: begin
        mreq.a = rho_mag;
        mreq.b = th_mag;
      end
      OP_PX: begin
        mreq.a = rho_mag;
        mreq.b = {1'b0, rx_r};
      end
      OP_PY: begin
        mreq.a = rho_mag;
        mreq.b = {1'b0, ry_r};
      end
      OP_XC: begin
        mreq.a = px_r;
        mreq.b = c_mag;
      end
      OP_YD: begin
        mreq.a = py_r;
        mreq.b = d_mag;
      end
      OP_XE: begin
        mreq.a = px_r;
        mreq.b = e_mag;
      end
      default: ;
    endcase
    if (state_r == S_MUL) begin
      case (op_r)
        OP_HORN: mneg_nxt = rho_r[COEF_W-1] ^ theta_r[31];
        OP_PX:   mneg_nxt = rho_r[COEF_W-1] ^ x_neg_r;
        OP_PY:   mneg_nxt = rho_r[COEF_W-1] ^ y_neg_r;
        OP_XC:   mneg_nxt = px_neg_r ^ affine_c_r[31];
        OP_YD:   mneg_nxt = py_neg_r ^ affine_d_r[31];
        OP_XE:   mneg_nxt = px_neg_r ^ affine_e_r[31];
        default: mneg_nxt = 1'b0;
      endcase
    end
  end

  // sequencer
  always_comb begin
    logic [35:0]              r2, t2;
    logic signed [CORD_W-1:0] sx, sy;
    logic [32:0]              dr;
    logic [61:0]              num;
    logic [30:0]              q;
    logic [PROD_W:0]          p30, p38;
    logic [50:0]              r30;
    logic [42:0]              r38;
    logic signed [HSUM_W-1:0] hterm, hsum;
    logic signed [ACC_W-1:0]  t38, colf, rowf, pyr;
    logic [48:0]              pys;
    logic                     sf;

    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    div_y_nxt     = div_y_r;
    out_valid_nxt = out_valid_r;
    ax_nxt = ax_r;  ay_nxt = ay_r;  az_nxt = az_r;
    x_neg_nxt = x_neg_r;  y_neg_nxt = y_neg_r;  z_neg_nxt = z_neg_r;
    sq_nxt = sq_r;  srem_nxt = srem_r;  root_nxt = root_r;  norm_nxt = norm_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  theta_nxt = theta_r;
    drem_nxt = drem_r;  dlow_nxt = dlow_r;  dq_nxt = dq_r;  rx_nxt = rx_r;  ry_nxt = ry_r;
    rho_nxt = rho_r;  idx_nxt = idx_r;  ncoef_nxt = ncoef_r;  rd_idx_nxt = rd_idx_r;
    px_nxt = px_r;  py_nxt = py_r;  px_neg_nxt = px_neg_r;  py_neg_nxt = py_neg_r;
    col_nxt = col_r;  row_nxt = row_r;  satf_nxt = satf_r;  onaxis_nxt = onaxis_r;
    out_col_nxt = out_col_r;  out_row_nxt = out_row_r;
    out_on_nxt = out_on_r;  out_sat_nxt = out_sat_r;

    // step values of the iterative units
    r2  = {srem_r, sq_r[63:62]};
    t2  = {2'b00, root_r, 2'b01};
    sx  = cx_r >>> cnt_r[4:0];
    sy  = cy_r >>> cnt_r[4:0];
    dr  = {drem_r, dlow_r[30]};
    q   = {dq_r[29:0], (dr >= {1'b0, norm_r})};
    num = {ay_r[31:0], 30'd0} + 62'(norm_r >> 1);
    p30 = {1'b0, mrsp.prod} + (81'd1 << 29);
    p38 = {1'b0, mrsp.prod} + (81'd1 << 37);
    r30 = p30[80:30];
    r38 = p38[80:38];
    hterm = mneg_r ? -signed'({2'b00, r30}) : signed'({2'b00, r30});
    hsum  = hterm + HSUM_W'(coef_q_r);
    t38   = mneg_r ? -signed'({2'b00, r38}) : signed'({2'b00, r38});
    pys   = {1'b0, py_r} + 49'd128;
    pyr   = py_neg_r ? -signed'(ACC_W'(pys[48:8])) : signed'(ACC_W'(pys[48:8]));
    colf  = col_r + ACC_W'(center_col_r);
    rowf  = row_r + pyr + ACC_W'(center_row_r);
    sf    = 1'b0;

    // output register drains independently of the sequencer
    if (out_chan.valid && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_chan.mode == MODE_PROJECT)) begin
          rd_idx_nxt = '0;
          satf_nxt   = 1'b0;
          if (cc == 5'd0) begin
            ncoef_nxt = CNTW'(1);
          end else if (32'(cc) > MAX_COEFS) begin
            ncoef_nxt = CNTW'(MAX_COEFS);
          end else begin
            ncoef_nxt = CNTW'(cc);
          end
          if ((in_chan.point_x == '0) && (in_chan.point_y == '0)) begin
            col_nxt    = ACC_W'(center_col_r);
            row_nxt    = ACC_W'(center_row_r);
            onaxis_nxt = 1'b1;
            state_nxt  = S_OUT;
          end else begin
            ax_nxt     = MW'(x_mag);
            ay_nxt     = MW'(y_mag);
            az_nxt     = MW'(z_mag);
            x_neg_nxt  = in_chan.point_x[COORD_WIDTH-1];
            y_neg_nxt  = in_chan.point_y[COORD_WIDTH-1];
            z_neg_nxt  = in_chan.point_z[COORD_WIDTH-1];
            onaxis_nxt = 1'b0;
            state_nxt  = S_SHIFT;
          end
        end
      end

      // bring x and y into 32 bits together with z
      S_SHIFT: begin
        if ((ax_r > MAG_LIM) || (ay_r > MAG_LIM)) begin
          ax_nxt = ax_r >> 1;
          ay_nxt = ay_r >> 1;
          az_nxt = az_r >> 1;
        end else begin
          op_nxt    = OP_SQX;
          state_nxt = S_MUL;
        end
      end

      // integer square root, two bits of the radicand a step
      S_SQRT: begin
        sq_nxt = sq_r << 2;
        if (r2 >= t2) begin
          srem_nxt = 34'(r2 - t2);
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          srem_nxt = r2[33:0];
          root_nxt = {root_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          norm_nxt  = root_nxt;
          cx_nxt    = CORD_W'(root_nxt);
          cy_nxt    = z_neg_r ? -signed'(CORD_W'(az_r)) : signed'(CORD_W'(az_r));
          theta_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = S_CORD;
        end
      end

      // cordic vectoring on (norm, z)
      S_CORD: begin
        if (cy_r > 0) begin
          cx_nxt    = cx_r + sy;
          cy_nxt    = cy_r - sx;
          theta_nxt = theta_r + signed'(atan_q30(cnt_r[4:0]));
        end else if (cy_r < 0) begin
          cx_nxt    = cx_r - sy;
          cy_nxt    = cy_r + sx;
          theta_nxt = theta_r - signed'(atan_q30(cnt_r[4:0]));
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(CORDIC_STEPS - 1)) begin
          num       = {ax_r[31:0], 30'd0} + 62'(norm_r >> 1);
          drem_nxt  = {1'b0, num[61:31]};
          dlow_nxt  = num[30:0];
          div_y_nxt = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end

      // restoring division of |x| and then |y| by norm, one quotient bit a step
      S_DIV: begin
        drem_nxt = (dr >= {1'b0, norm_r}) ? 32'(dr - {1'b0, norm_r}) : dr[31:0];
        dlow_nxt = dlow_r << 1;
        dq_nxt   = q;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'd30) begin
          cnt_nxt = '0;
          if (!div_y_r) begin
            rx_nxt    = q;
            drem_nxt  = {1'b0, num[61:31]};
            dlow_nxt  = num[30:0];
            div_y_nxt = 1'b1;
          end else begin
            ry_nxt    = q;
            state_nxt = S_HLOAD;
          end
        end
      end

      // leading coefficient
      S_HLOAD: begin
        rho_nxt    = coef_q_r;
        idx_nxt    = CNTW'(1);
        rd_idx_nxt = CIW'(1);
        op_nxt     = (ncoef_r == CNTW'(1)) ? OP_PX : OP_HORN;
        state_nxt  = S_MUL;
      end

      S_MUL: begin
        state_nxt = S_MWAIT;
      end

      // consume a finished product
      S_MWAIT: begin
        if (mrsp.done) begin
          state_nxt = S_MUL;
          case (op_r)
            OP_SQX: begin
              sq_nxt = mrsp.prod[63:0];
              op_nxt = OP_SQY;
            end
            OP_SQY: begin
              sq_nxt    = sq_r + mrsp.prod[63:0];
              srem_nxt  = '0;
              root_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = S_SQRT;
            end
            OP_HORN: begin
              if (hsum > HSUM_MAX) begin
                rho_nxt  = HSUM_MAX[COEF_W-1:0];
                satf_nxt = 1'b1;
              end else if (hsum < HSUM_MIN) begin
                rho_nxt  = HSUM_MIN[COEF_W-1:0];
                satf_nxt = 1'b1;
              end else begin
                rho_nxt = hsum[COEF_W-1:0];
              end
              idx_nxt    = idx_r + CNTW'(1);
              rd_idx_nxt = CIW'(idx_r + CNTW'(1));
              if (idx_nxt == ncoef_r) begin
                op_nxt = OP_PX;
              end
            end
            OP_PX: begin
              px_nxt     = r30[47:0];
              px_neg_nxt = mneg_r;
              op_nxt     = OP_PY;
            end
            OP_PY: begin
              py_nxt     = r30[47:0];
              py_neg_nxt = mneg_r;
              op_nxt     = OP_XC;
            end
            OP_XC: begin
              col_nxt = t38;
              op_nxt  = OP_YD;
            end
            OP_YD: begin
              col_nxt = col_r + t38;
              op_nxt  = OP_XE;
            end
            OP_XE: begin
              row_nxt   = t38;
              state_nxt = S_FIN;
            end
            default: ;
          endcase
        end
      end

      // add the centre and clip to 32 bits
      S_FIN: begin
        if (colf > PIX_MAX) begin
          col_nxt = PIX_MAX;
          sf      = 1'b1;
        end else if (colf < PIX_MIN) begin
          col_nxt = PIX_MIN;
          sf      = 1'b1;
        end else begin
          col_nxt = colf;
        end
        if (rowf > PIX_MAX) begin
          row_nxt = PIX_MAX;
          sf      = 1'b1;
        end else if (rowf < PIX_MIN) begin
          row_nxt = PIX_MIN;
          sf      = 1'b1;
        end else begin
          row_nxt = rowf;
        end
        satf_nxt  = satf_r | sf;
        state_nxt = S_OUT;
      end

      // hand the item to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = col_r[PIX_W-1:0];
          out_row_nxt   = row_r[PIX_W-1:0];
          out_on_nxt    = onaxis_r;
          out_sat_nxt   = satf_r & ~onaxis_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_SQX;
      cnt_r       <= '0;
      div_y_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      div_y_r     <= div_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ax_r <= ax_nxt;  ay_r <= ay_nxt;  az_r <= az_nxt;
    x_neg_r <= x_neg_nxt;  y_neg_r <= y_neg_nxt;  z_neg_r <= z_neg_nxt;
    sq_r <= sq_nxt;  srem_r <= srem_nxt;  root_r <= root_nxt;  norm_r <= norm_nxt;
    cx_r <= cx_nxt;  cy_r <= cy_nxt;  theta_r <= theta_nxt;
    drem_r <= drem_nxt;  dlow_r <= dlow_nxt;  dq_r <= dq_nxt;
    rx_r <= rx_nxt;  ry_r <= ry_nxt;
    rho_r <= rho_nxt;  idx_r <= idx_nxt;  ncoef_r <= ncoef_nxt;  rd_idx_r <= rd_idx_nxt;
    px_r <= px_nxt;  py_r <= py_nxt;  px_neg_r <= px_neg_nxt;  py_neg_r <= py_neg_nxt;
    mneg_r <= mneg_nxt;
    col_r <= col_nxt;  row_r <= row_nxt;  satf_r <= satf_nxt;  onaxis_r <= onaxis_nxt;
    out_col_r <= out_col_nxt;  out_row_r <= out_row_nxt;
    out_on_r <= out_on_nxt;  out_sat_r <= out_sat_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pixel_col = out_col_r;
  assign out_chan.pixel_row = out_row_r;
  assign out_chan.on_axis   = out_on_r;
  assign out_chan.saturated = out_sat_r;

  // products only come back while the sequencer waits for one
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> state_r == S_MWAIT)
    else $error("multiplier result outside wait state");

  // the divisor is never zero once the square root has run
  a_norm_nz: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> norm_r != 32'd0)
    else $error("zero norm in division");

  // an on-axis result never reports clipping
  a_axis_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.on_axis |-> !out_chan.saturated)
    else $error("on-axis item flagged as saturated");

  // a finished item reaches the output register on the cycle it leaves the output state
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && state_nxt == S_IDLE |=> out_chan.valid)
    else $error("result lost on the way to the output register");

endmodule
